[rtl/core/depth_to_point_unproject_assert.svh]
// Assertion macros for the depth-to-point unprojection block.
// Used by files that assert; expects signals named clock and reset in scope.
`ifndef DEPTH_TO_POINT_UNPROJECT_ASSERT_SVH
`define DEPTH_TO_POINT_UNPROJECT_ASSERT_SVH

// same-cycle implication
`define DTPU_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dtpu assertion failed");

// next-cycle implication
`define DTPU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dtpu assertion failed");

`endif

[rtl/core/dtpu_pkg.sv]
// Package for the depth-to-point unprojection block.
// Widths, register indexes, reset values and sideband structs; no dependencies.
package dtpu_pkg;

   localparam int IMAGE_WIDTH_DEF  = 1024;
   localparam int IMAGE_HEIGHT_DEF = 1024;

   localparam int COORD_W     = 12;
   localparam int DEPTH_W     = 16;
   localparam int COLOR_W     = 32;
   localparam int POINT_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // quotient bits per divider, one per stage
   localparam int DIV_STEPS    = 31;
   localparam int WORLD_STAGES = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROT_A,
      CSR_ROT_B,
      CSR_ROT_C,
      CSR_TRANS_MODE,
      CSR_FOCAL,
      CSR_PRINCIPAL,
      CSR_CLIP,
      CSR_WINDOW
   } csr_index_type;

   localparam logic [47:0] ROT_A_RST       = 48'h4000_0000_0000;
   localparam logic [47:0] ROT_B_RST       = 48'h0000_4000_0000;
   localparam logic [47:0] ROT_C_RST       = 48'h0000_0000_4000;
   localparam logic [48:0] TRANS_MODE_RST  = 49'h0;
   localparam logic [31:0] FOCAL_RST       = 32'h1000_1000;
   localparam logic [31:0] PRINCIPAL_RST   = 32'h0;
   localparam logic [63:0] CLIP_RST        = 64'h0001_86A0_0000_0000;
   localparam logic [63:0] WINDOW_RST      = 64'hFFFF_0000_0000_0000;

   localparam logic signed [POINT_W-1:0] POINT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [POINT_W-1:0] POINT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [COLOR_W-1:0] color;
      logic               ok;
   } point_meta_type;

   typedef struct packed {
      logic               ok;
      logic               dneg;
      logic               zsat;
      logic [COLOR_W-1:0] color;
   } zside_type;

   typedef struct packed {
      logic               yneg;
      logic [COORD_W-1:0] row;
   } yside_type;

   typedef struct packed {
      logic                        neg;
      logic                        sat;
      logic signed [POINT_W-1:0]   z;
      point_meta_type              meta;
   } xside_type;

   typedef struct packed {
      logic neg;
      logic sat;
   } yqside_type;

   typedef struct packed {
      logic [47:0] rot_a;
      logic [47:0] rot_b;
      logic [47:0] rot_c;
      logic [47:0] trans;
      logic        world;
   } world_cfg_type;

endpackage

[rtl/core/dtpu_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Generic widths; carries a sideband vector alongside. Depends on nothing.
module dtpu_div_pipe #(
   parameter int DW = 16,
   parameter int QW = 31,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] start_rem,
   input  logic [QW-1:0] start_low,
   input  logic [DW-1:0] divisor,
   input  logic [SW-1:0] side_start,
   output logic [QW-1:0] quotient,
   output logic [SW-1:0] side_done
);

   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] low_ff  [QW];
   logic [QW-1:0] quot_ff [QW];
   logic [DW-1:0] div_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   logic [DW-1:0] rem_in  [QW];
   logic [QW-1:0] low_in  [QW];
   logic [QW-1:0] quot_in [QW];
   logic [DW-1:0] div_in  [QW];
   logic [SW-1:0] side_in [QW];

   always_comb begin
      logic [DW-1:0] pr;
      logic [QW-1:0] pl;
      logic [QW-1:0] pq;
      logic [DW-1:0] pd;
      logic [SW-1:0] ps;
      logic [DW:0]   trial;
      logic          ge;
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            pr = start_rem;
            pl = start_low;
            pq = '0;
            pd = divisor;
            ps = side_start;
         end else begin
            pr = rem_ff[k-1];
            pl = low_ff[k-1];
            pq = quot_ff[k-1];
            pd = div_ff[k-1];
            ps = side_ff[k-1];
         end
         trial      = {pr, pl[QW-1]};
         ge         = trial >= {1'b0, pd};
         rem_in[k]  = ge ? DW'(trial - {1'b0, pd}) : trial[DW-1:0];
         low_in[k]  = pl << 1;
         quot_in[k] = {pq[QW-2:0], ge};
         div_in[k]  = pd;
         side_in[k] = ps;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            rem_ff[k]  <= rem_in[k];
            low_ff[k]  <= low_in[k];
            quot_ff[k] <= quot_in[k];
            div_ff[k]  <= div_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign quotient  = quot_ff[QW-1];
   assign side_done = side_ff[QW-1];

endmodule

[rtl/core/dtpu_world_xform.sv]
// World transform: translate, rotate, floor-shift, saturate or bypass; 4 stages.
// Depends on dtpu_pkg for config and sideband structs.
module dtpu_world_xform (
   input  logic                                 clock,
   input  logic                                 en,
   input  dtpu_pkg::world_cfg_type              cfg,
   input  logic signed [dtpu_pkg::POINT_W-1:0]  cam_x,
   input  logic signed [dtpu_pkg::POINT_W-1:0]  cam_y,
   input  logic signed [dtpu_pkg::POINT_W-1:0]  cam_z,
   input  dtpu_pkg::point_meta_type             meta_start,
   output logic signed [dtpu_pkg::POINT_W-1:0]  pt_x,
   output logic signed [dtpu_pkg::POINT_W-1:0]  pt_y,
   output logic signed [dtpu_pkg::POINT_W-1:0]  pt_z,
   output dtpu_pkg::point_meta_type             meta_done
);
   import dtpu_pkg::*;

   logic signed [15:0] tx, ty, tz;
   logic signed [15:0] rot [3][3];

   logic signed [33:0]        p_ff    [3];
   logic signed [49:0]        prod_ff [3][3];
   logic signed [51:0]        sum_ff  [3];
   logic signed [POINT_W-1:0] cam1_ff [3];
   logic signed [POINT_W-1:0] cam2_ff [3];
   logic signed [POINT_W-1:0] cam3_ff [3];
   logic signed [POINT_W-1:0] out_ff  [3];
   point_meta_type            meta1_ff, meta2_ff, meta3_ff, meta4_ff;

   logic signed [33:0]        p_in   [3];
   logic signed [POINT_W-1:0] out_in [3];

   assign tx = $signed(cfg.trans[47:32]);
   assign ty = $signed(cfg.trans[31:16]);
   assign tz = $signed(cfg.trans[15:0]);

   always_comb begin
      rot[0][0] = $signed(cfg.rot_a[47:32]);
      rot[0][1] = $signed(cfg.rot_a[31:16]);
      rot[0][2] = $signed(cfg.rot_a[15:0]);
      rot[1][0] = $signed(cfg.rot_b[47:32]);
      rot[1][1] = $signed(cfg.rot_b[31:16]);
      rot[1][2] = $signed(cfg.rot_b[15:0]);
      rot[2][0] = $signed(cfg.rot_c[47:32]);
      rot[2][1] = $signed(cfg.rot_c[31:16]);
      rot[2][2] = $signed(cfg.rot_c[15:0]);
   end

   assign p_in[0] = 34'(cam_x) - (34'(tx) <<< 8);
   assign p_in[1] = 34'(cam_y) - (34'(ty) <<< 8);
   assign p_in[2] = -34'(cam_z) - (34'(tz) <<< 8);

   always_comb begin
      logic signed [51:0] sh;
      for (int k = 0; k < 3; k++) begin
         sh = sum_ff[k] >>> 14;
         if (!cfg.world) begin
            out_in[k] = cam3_ff[k];
         end else if (sh > 52'(POINT_MAX)) begin
            out_in[k] = POINT_MAX;
         end else if (sh < 52'(POINT_MIN)) begin
            out_in[k] = POINT_MIN;
         end else begin
            out_in[k] = sh[POINT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cam1_ff[0] <= cam_x;
         cam1_ff[1] <= cam_y;
         cam1_ff[2] <= cam_z;
         for (int k = 0; k < 3; k++) begin
            p_ff[k]    <= p_in[k];
            cam2_ff[k] <= cam1_ff[k];
            cam3_ff[k] <= cam2_ff[k];
            out_ff[k]  <= out_in[k];
            sum_ff[k]  <= 52'(prod_ff[k][0]) + 52'(prod_ff[k][1]) + 52'(prod_ff[k][2]);
            for (int j = 0; j < 3; j++) begin
               prod_ff[k][j] <= 50'(rot[k][j]) * 50'(p_ff[j]);
            end
         end
         meta1_ff <= meta_start;
         meta2_ff <= meta1_ff;
         meta3_ff <= meta2_ff;
         meta4_ff <= meta3_ff;
      end
   end

   assign pt_x      = out_ff[0];
   assign pt_y      = out_ff[1];
   assign pt_z      = out_ff[2];
   assign meta_done = meta4_ff;

endmodule

[rtl/core/depth_to_point_unproject.sv]
// Top level of the depth-to-point unprojection block.
// Uses dtpu_pkg, dtpu_div_pipe, dtpu_world_xform and the assertion macro header.
//
// Takes one depth pixel per clock while the output does not stall and returns
// one point per pixel, in order. Two chained banks of 31-stage restoring
// dividers do the division: the first forms the linearised depth and the ndc
// terms, the second pair forms camera x and y. A one-transaction input buffer
// takes an item offered while the output stalls; the whole pipeline then holds
// until the result is taken. The csr_ port is always ready; the user must
// write configuration only while the block is idle, which it does not enforce.
`include "depth_to_point_unproject_assert.svh"

module depth_to_point_unproject #(
   parameter int IMAGE_WIDTH  = dtpu_pkg::IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = dtpu_pkg::IMAGE_HEIGHT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [dtpu_pkg::COORD_W-1:0]           req_pixel_column,
   input  logic [dtpu_pkg::COORD_W-1:0]           req_pixel_row,
   input  logic [dtpu_pkg::DEPTH_W-1:0]           req_depth_sample,
   input  logic [dtpu_pkg::COLOR_W-1:0]           req_pixel_color,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_point_valid,
   output logic signed [dtpu_pkg::POINT_W-1:0]    rsp_point_x,
   output logic signed [dtpu_pkg::POINT_W-1:0]    rsp_point_y,
   output logic signed [dtpu_pkg::POINT_W-1:0]    rsp_point_z,
   output logic [dtpu_pkg::COLOR_W-1:0]           rsp_point_color,
   output logic [dtpu_pkg::COORD_W-1:0]           rsp_out_column,
   output logic [dtpu_pkg::COORD_W-1:0]           rsp_out_row,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dtpu_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [dtpu_pkg::CSR_DATA_W-1:0]        csr_data
);
   import dtpu_pkg::*;

   localparam int LAT = 3 + DIV_STEPS + 4 + DIV_STEPS + 1 + WORLD_STAGES;

   // ---------------- configuration registers
   logic [47:0] rot_a_ff, rot_b_ff, rot_c_ff;
   logic [48:0] trans_ff;
   logic [31:0] focal_ff, principal_ff;
   logic [63:0] clip_ff, window_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_a_ff     <= ROT_A_RST;
         rot_b_ff     <= ROT_B_RST;
         rot_c_ff     <= ROT_C_RST;
         trans_ff     <= TRANS_MODE_RST;
         focal_ff     <= FOCAL_RST;
         principal_ff <= PRINCIPAL_RST;
         clip_ff      <= CLIP_RST;
         window_ff    <= WINDOW_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ROT_A:      rot_a_ff     <= csr_data[47:0];
            CSR_ROT_B:      rot_b_ff     <= csr_data[47:0];
            CSR_ROT_C:      rot_c_ff     <= csr_data[47:0];
            CSR_TRANS_MODE: trans_ff     <= csr_data[48:0];
            CSR_FOCAL:      focal_ff     <= csr_data[31:0];
            CSR_PRINCIPAL:  principal_ff <= csr_data[31:0];
            CSR_CLIP:       clip_ff      <= csr_data;
            CSR_WINDOW:     window_ff    <= csr_data;
            default:        ;
         endcase
      end
   end

   logic [15:0]        win_hi, win_lo, vw, vh, fx_abs, fy_abs;
   logic signed [15:0] fx, fy, cx, cy;
   logic [31:0]        far_d, near_d;
   logic               world;

   assign win_hi = window_ff[63:48];
   assign win_lo = window_ff[47:32];
   assign vw     = window_ff[31:16];
   assign vh     = window_ff[15:0];
   assign fx     = $signed(focal_ff[31:16]);
   assign fy     = $signed(focal_ff[15:0]);
   assign cx     = $signed(principal_ff[31:16]);
   assign cy     = $signed(principal_ff[15:0]);
   assign far_d  = clip_ff[63:32];
   assign near_d = clip_ff[31:0];
   assign world  = trans_ff[48];
   assign fx_abs = focal_ff[31] ? (~focal_ff[31:16] + 16'd1) : focal_ff[31:16];
   assign fy_abs = focal_ff[15] ? (~focal_ff[15:0] + 16'd1) : focal_ff[15:0];

   // ---------------- pipeline control and input buffer
   logic               pipe_en;
   logic [LAT-1:0]     occ_ff;
   logic               skid_full_ff;
   logic [COORD_W-1:0] skid_col_ff, skid_row_ff;
   logic [DEPTH_W-1:0] skid_depth_ff;
   logic [COLOR_W-1:0] skid_color_ff;
   logic [COORD_W-1:0] src_col, src_row;
   logic [DEPTH_W-1:0] src_depth;
   logic [COLOR_W-1:0] src_color;
   logic               src_valid;

   assign pipe_en   = !occ_ff[LAT-1] || !rsp_stall;
   assign req_stall = skid_full_ff;
   assign src_valid = skid_full_ff || req_valid;
   assign src_col   = skid_full_ff ? skid_col_ff   : req_pixel_column;
   assign src_row   = skid_full_ff ? skid_row_ff   : req_pixel_row;
   assign src_depth = skid_full_ff ? skid_depth_ff : req_depth_sample;
   assign src_color = skid_full_ff ? skid_color_ff : req_pixel_color;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
         occ_ff       <= '0;
      end else begin
         skid_full_ff <= pipe_en ? 1'b0 : (skid_full_ff || req_valid);
         if (pipe_en) begin
            occ_ff <= {occ_ff[LAT-2:0], src_valid};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff && !pipe_en) begin
         skid_col_ff   <= req_pixel_column;
         skid_row_ff   <= req_pixel_row;
         skid_depth_ff <= req_depth_sample;
         skid_color_ff <= req_pixel_color;
      end
   end

   // ---------------- stage 1: checks, near*far, depth divisor, y row term
   logic               s1_ok_in;
   logic signed [17:0] zn, s1_wy_in;
   logic signed [32:0] far_minus_near;
   logic signed [50:0] zprod;
   logic [32:0]        near_plus_far;
   logic signed [51:0] s1_den_in;

   assign s1_ok_in = ({1'b0, src_col} < 13'(IMAGE_WIDTH)) &&
                     ({1'b0, src_row} < 13'(IMAGE_HEIGHT)) &&
                     (src_depth > win_lo) && (src_depth < win_hi) &&
                     (vw != 16'd0) && (vh != 16'd0) &&
                     (fx != 16'sd0) && (fy != 16'sd0);
   assign zn             = $signed({1'b0, src_depth, 1'b0}) - 18'sd65536;
   assign far_minus_near = $signed({1'b0, far_d}) - $signed({1'b0, near_d});
   assign zprod          = zn * far_minus_near;
   assign near_plus_far  = {1'b0, near_d} + {1'b0, far_d};
   assign s1_den_in      = $signed({3'b000, near_plus_far, 16'h0000}) - 52'(zprod);
   assign s1_wy_in       = world ? ($signed({2'b00, vh}) - $signed({6'd0, src_row}) - 18'sd1)
                                 : $signed({6'd0, src_row});

   logic               s1_ok_ff;
   logic [63:0]        s1_num_ff;
   logic signed [51:0] s1_den_ff;
   logic signed [17:0] s1_wy_ff;
   logic [COORD_W-1:0] s1_col_ff, s1_row_ff;
   logic [COLOR_W-1:0] s1_color_ff;

   // ---------------- stage 2: magnitudes
   logic signed [51:0] den_abs_full;
   logic signed [17:0] wy_abs_full;

   assign den_abs_full = s1_den_ff[51] ? -s1_den_ff : s1_den_ff;
   assign wy_abs_full  = s1_wy_ff[17]  ? -s1_wy_ff  : s1_wy_ff;

   logic               s2_ok_ff, s2_dneg_ff, s2_yneg_ff;
   logic [63:0]        s2_num_ff;
   logic [49:0]        s2_dabs_ff;
   logic [16:0]        s2_yabs_ff;
   logic [COORD_W-1:0] s2_col_ff, s2_row_ff;
   logic [COLOR_W-1:0] s2_color_ff;

   // ---------------- stage 3: divider setup
   logic               s3_ok_ff, s3_dneg_ff, s3_yneg_ff, s3_zsat_ff;
   logic [49:0]        s3_zrem_ff, s3_dabs_ff;
   logic [30:0]        s3_zlow_ff;
   logic [16:0]        s3_yabs_ff;
   logic [COORD_W-1:0] s3_col_ff, s3_row_ff;
   logic [COLOR_W-1:0] s3_color_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_ok_ff    <= s1_ok_in;
         s1_num_ff   <= {32'd0, near_d} * {32'd0, far_d};
         s1_den_ff   <= s1_den_in;
         s1_wy_ff    <= s1_wy_in;
         s1_col_ff   <= src_col;
         s1_row_ff   <= src_row;
         s1_color_ff <= src_color;

         s2_ok_ff    <= s1_ok_ff && (s1_den_ff != 52'sd0);
         s2_dneg_ff  <= s1_den_ff[51];
         s2_num_ff   <= s1_num_ff;
         s2_dabs_ff  <= den_abs_full[49:0];
         s2_yneg_ff  <= s1_wy_ff[17];
         s2_yabs_ff  <= wy_abs_full[16:0];
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
         s2_color_ff <= s1_color_ff;

         s3_ok_ff    <= s2_ok_ff;
         s3_dneg_ff  <= s2_dneg_ff;
         s3_zsat_ff  <= s2_num_ff >= {s2_dabs_ff, 14'd0};
         s3_zrem_ff  <= s2_num_ff[63:14];
         s3_zlow_ff  <= {s2_num_ff[13:0], 17'd0};
         s3_dabs_ff  <= s2_dabs_ff;
         s3_yneg_ff  <= s2_yneg_ff;
         s3_yabs_ff  <= s2_yabs_ff;
         s3_col_ff   <= s2_col_ff;
         s3_row_ff   <= s2_row_ff;
         s3_color_ff <= s2_color_ff;
      end
   end

   // ---------------- first divider bank: depth and ndc terms
   zside_type          zs_start, zs_done;
   yside_type          ys_start, ys_done;
   logic [COORD_W-1:0] xs_done;
   logic [30:0]        qz, qx, qy;

   assign zs_start = '{ok: s3_ok_ff, dneg: s3_dneg_ff, zsat: s3_zsat_ff, color: s3_color_ff};
   assign ys_start = '{yneg: s3_yneg_ff, row: s3_row_ff};

   dtpu_div_pipe #(.DW(50), .QW(DIV_STEPS), .SW($bits(zside_type))) u_div_z (
      .clock(clock), .en(pipe_en),
      .start_rem(s3_zrem_ff), .start_low(s3_zlow_ff), .divisor(s3_dabs_ff),
      .side_start(zs_start), .quotient(qz), .side_done(zs_done)
   );

   dtpu_div_pipe #(.DW(16), .QW(DIV_STEPS), .SW(COORD_W)) u_div_nx (
      .clock(clock), .en(pipe_en),
      .start_rem(16'd0), .start_low({2'b00, s3_col_ff, 17'd0}), .divisor(vw),
      .side_start(s3_col_ff), .quotient(qx), .side_done(xs_done)
   );

   dtpu_div_pipe #(.DW(16), .QW(DIV_STEPS), .SW($bits(yside_type))) u_div_ny (
      .clock(clock), .en(pipe_en),
      .start_rem({13'd0, s3_yabs_ff[16:14]}), .start_low({s3_yabs_ff[13:0], 17'd0}),
      .divisor(vh), .side_start(ys_start), .quotient(qy), .side_done(ys_done)
   );

   // ---------------- stage 4: signed z and ndc
   logic [30:0]               zmag;
   logic signed [POINT_W-1:0] qy_signed;

   assign zmag      = zs_done.zsat ? 31'h7FFF_FFFF : qz;
   assign qy_signed = ys_done.yneg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

   logic signed [POINT_W-1:0] s4_z_ff, s4_ndcx_ff, s4_ndcy_ff;
   point_meta_type            s4_meta_ff, s5_meta_ff, s6_meta_ff, s7_meta_ff;
   logic signed [POINT_W-1:0] s5_z_ff, s6_z_ff, s7_z_ff;
   logic signed [63:0]        s5_px_ff, s5_py_ff;
   logic [62:0]               s6_pxabs_ff, s6_pyabs_ff;
   logic                      s6_xneg_ff, s6_yneg_ff;
   logic signed [63:0]        px_abs_full, py_abs_full;

   assign px_abs_full = s5_px_ff[63] ? -s5_px_ff : s5_px_ff;
   assign py_abs_full = s5_py_ff[63] ? -s5_py_ff : s5_py_ff;

   // ---------------- stage 7: second divider setup
   logic        s7_xneg_ff, s7_yneg_ff, s7_xsat_ff, s7_ysat_ff;
   logic [19:0] s7_xrem_ff, s7_yrem_ff;
   logic [30:0] s7_xlow_ff, s7_ylow_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_z_ff    <= zs_done.dneg ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
         s4_ndcx_ff <= $signed({1'b0, qx}) - 32'sd65536 + (32'(cx) <<< 4);
         s4_ndcy_ff <= qy_signed - 32'sd65536 + (32'(cy) <<< 4);
         s4_meta_ff <= '{col: xs_done, row: ys_done.row, color: zs_done.color,
                         ok: zs_done.ok};

         s5_px_ff   <= 64'(s4_ndcx_ff) * 64'(s4_z_ff);
         s5_py_ff   <= 64'(s4_ndcy_ff) * 64'(s4_z_ff);
         s5_z_ff    <= s4_z_ff;
         s5_meta_ff <= s4_meta_ff;

         s6_pxabs_ff <= px_abs_full[62:0];
         s6_pyabs_ff <= py_abs_full[62:0];
         s6_xneg_ff  <= s5_px_ff[63] ^ fx[15];
         s6_yneg_ff  <= s5_py_ff[63] ^ fy[15];
         s6_z_ff     <= s5_z_ff;
         s6_meta_ff  <= s5_meta_ff;

         s7_xsat_ff <= s6_pxabs_ff >= {12'd0, fx_abs, 4'd0, 31'd0};
         s7_ysat_ff <= s6_pyabs_ff >= {12'd0, fy_abs, 4'd0, 31'd0};
         s7_xrem_ff <= s6_pxabs_ff[50:31];
         s7_yrem_ff <= s6_pyabs_ff[50:31];
         s7_xlow_ff <= s6_pxabs_ff[30:0];
         s7_ylow_ff <= s6_pyabs_ff[30:0];
         s7_xneg_ff <= s6_xneg_ff;
         s7_yneg_ff <= s6_yneg_ff;
         s7_z_ff    <= s6_z_ff;
         s7_meta_ff <= s6_meta_ff;
      end
   end

   // ---------------- second divider bank: camera x and y
   xside_type   xq_start, xq_done;
   yqside_type  yq_start, yq_done;
   logic [30:0] qxo, qyo;

   assign xq_start = '{neg: s7_xneg_ff, sat: s7_xsat_ff, z: s7_z_ff, meta: s7_meta_ff};
   assign yq_start = '{neg: s7_yneg_ff, sat: s7_ysat_ff};

   dtpu_div_pipe #(.DW(20), .QW(DIV_STEPS), .SW($bits(xside_type))) u_div_x (
      .clock(clock), .en(pipe_en),
      .start_rem(s7_xrem_ff), .start_low(s7_xlow_ff), .divisor({fx_abs, 4'd0}),
      .side_start(xq_start), .quotient(qxo), .side_done(xq_done)
   );

   dtpu_div_pipe #(.DW(20), .QW(DIV_STEPS), .SW($bits(yqside_type))) u_div_y (
      .clock(clock), .en(pipe_en),
      .start_rem(s7_yrem_ff), .start_low(s7_ylow_ff), .divisor({fy_abs, 4'd0}),
      .side_start(yq_start), .quotient(qyo), .side_done(yq_done)
   );

   // ---------------- stage 8: sign and saturate
   logic signed [POINT_W-1:0] s8_x_ff, s8_y_ff, s8_z_ff;
   point_meta_type            s8_meta_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         if (xq_done.sat) begin
            s8_x_ff <= xq_done.neg ? POINT_MIN : POINT_MAX;
         end else begin
            s8_x_ff <= xq_done.neg ? -$signed({1'b0, qxo}) : $signed({1'b0, qxo});
         end
         if (yq_done.sat) begin
            s8_y_ff <= yq_done.neg ? POINT_MIN : POINT_MAX;
         end else begin
            s8_y_ff <= yq_done.neg ? -$signed({1'b0, qyo}) : $signed({1'b0, qyo});
         end
         s8_z_ff    <= xq_done.z;
         s8_meta_ff <= xq_done.meta;
      end
   end

   // ---------------- world transform and output
   world_cfg_type             wcfg;
   logic signed [POINT_W-1:0] wx, wy_pt, wz;
   point_meta_type            meta_out;

   assign wcfg = '{rot_a: rot_a_ff, rot_b: rot_b_ff, rot_c: rot_c_ff,
                   trans: trans_ff[47:0], world: world};

   dtpu_world_xform u_world (
      .clock(clock), .en(pipe_en), .cfg(wcfg),
      .cam_x(s8_x_ff), .cam_y(s8_y_ff), .cam_z(s8_z_ff), .meta_start(s8_meta_ff),
      .pt_x(wx), .pt_y(wy_pt), .pt_z(wz), .meta_done(meta_out)
   );

   assign rsp_valid       = occ_ff[LAT-1];
   assign rsp_point_valid = meta_out.ok;
   assign rsp_point_x     = meta_out.ok ? wx    : '0;
   assign rsp_point_y     = meta_out.ok ? wy_pt : '0;
   assign rsp_point_z     = meta_out.ok ? wz    : '0;
   assign rsp_point_color = meta_out.ok ? meta_out.color : '0;
   assign rsp_out_column  = meta_out.col;
   assign rsp_out_row     = meta_out.row;

   // ---------------- assertions
   `DTPU_ASSERT_NEXT(a_result_held, rsp_valid && rsp_stall, rsp_valid)
   `DTPU_ASSERT_NEXT(a_skid_capture, req_valid && !req_stall && !pipe_en, skid_full_ff)
   `DTPU_ASSERT_IMPL(a_skid_from_stall, skid_full_ff, !$past(pipe_en))

endmodule
